/* src/tccw_pkg.sv */
// Shared types, constants and helper functions for the text console cursor writer.
package tccw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;

  localparam int ROW_W = 5;
  localparam int COL_W = 7;
  localparam int POS_W = 11;

  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_RETURN    = 8'd13;
  localparam logic [7:0] CHAR_SPACE     = 8'd32;

  localparam logic OP_PUT_CHAR     = 1'b0;
  localparam logic OP_CLEAR_SCREEN = 1'b1;

  localparam logic ADDR_TEXT_ATTRIBUTE = 1'b0;
  localparam logic [7:0] TEXT_ATTRIBUTE_RESET = 8'd7;

  typedef enum logic [1:0] {
    ACT_WRITE_CELL   = 2'd0,
    ACT_CLEAR_ROW    = 2'd1,
    ACT_CURSOR       = 2'd2,
    ACT_CLEAR_SCREEN = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic [7:0]         cell_char;
    logic [7:0]         cell_attribute;
    logic [POS_W-1:0]   cursor_position;
  } result_t;

  // up to four results caused by one input item
  typedef struct packed {
    result_t [3:0] slot;
    logic [2:0]    count;
  } batch_t;

  function automatic logic [POS_W-1:0] cursor_pos(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_W+COL_W:0] full;
    full = (ROW_W+COL_W+1)'(row) * (ROW_W+COL_W+1)'(SCREEN_COLUMNS)
         + (ROW_W+COL_W+1)'(col);
    return full[POS_W-1:0];
  endfunction

  function automatic result_t mk_cursor(input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col);
    result_t r;
    r.action          = ACT_CURSOR;
    r.row             = row;
    r.column          = col;
    r.cell_char       = '0;
    r.cell_attribute  = '0;
    r.cursor_position = cursor_pos(row, col);
    return r;
  endfunction

  function automatic result_t mk_write(input logic [ROW_W-1:0] row,
                                       input logic [COL_W-1:0] col,
                                       input logic [7:0] ch, input logic [7:0] attr);
    result_t r;
    r.action          = ACT_WRITE_CELL;
    r.row             = row;
    r.column          = col;
    r.cell_char       = ch;
    r.cell_attribute  = attr;
    r.cursor_position = '0;
    return r;
  endfunction

  function automatic result_t mk_clear_row(input logic [ROW_W-1:0] row,
                                           input logic [7:0] attr);
    result_t r;
    r.action          = ACT_CLEAR_ROW;
    r.row             = row;
    r.column          = '0;
    r.cell_char       = '0;
    r.cell_attribute  = attr;
    r.cursor_position = '0;
    return r;
  endfunction

  function automatic result_t mk_clear_screen();
    result_t r;
    r.action          = ACT_CLEAR_SCREEN;
    r.row             = '0;
    r.column          = '0;
    r.cell_char       = '0;
    r.cell_attribute  = '0;
    r.cursor_position = '0;
    return r;
  endfunction

endpackage

/* src/tccw_if.sv */
// Valid/ready channel interfaces for console commands and screen update beats.
interface tccw_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] char_code;

  modport source (output valid, output operation, output char_code, input ready);
  modport sink   (input valid, input operation, input char_code, output ready);
endinterface

interface tccw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [4:0]  row;
  logic [6:0]  column;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attribute;
  logic [10:0] cursor_position;
  logic        last;

  modport source (output valid, output action, output row, output column, output cell_char,
                  output cell_attribute, output cursor_position, output last, input ready);
  modport sink   (input valid, input action, input row, input column, input cell_char,
                  input cell_attribute, input cursor_position, input last, output ready);
endinterface

/* src/tccw_cfg.sv */
// APB-style register block holding the text attribute.
module tccw_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  text_attribute
);

  logic [7:0] attr_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == tccw_pkg::ADDR_TEXT_ATTRIBUTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tccw_pkg::TEXT_ATTRIBUTE_RESET;
    end else if (wr_en) begin
      attr_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr == tccw_pkg::ADDR_TEXT_ATTRIBUTE) ? {24'd0, attr_r} : 32'd0;
  assign text_attribute = attr_r;

endmodule

/* src/tccw_core.sv */
// Input register, cursor state and the decode that builds each item's result batch.
module tccw_core (
  input  logic               clk,
  input  logic               rst_n,
  tccw_in_if.sink            in_ch,
  input  logic [7:0]         text_attribute,
  output tccw_pkg::batch_t   batch,
  output logic               batch_valid,
  input  logic               batch_ready
);

  logic       in_v_r;
  logic       op_r;
  logic [7:0] ch_r;
  logic [tccw_pkg::COL_W-1:0] col_r, col_nxt;
  logic [tccw_pkg::ROW_W-1:0] row_r, row_nxt;
  logic       take;
  logic [tccw_pkg::ROW_W:0]   row_inc;
  logic [tccw_pkg::ROW_W-1:0] row_wrap;
  logic [tccw_pkg::COL_W:0]   col_inc;
  logic [tccw_pkg::COL_W-1:0] col_dec;
  logic       col_end;
  tccw_pkg::batch_t b;

  assign take        = in_v_r && batch_ready;
  // no beat is taken while reset is held
  assign in_ch.ready = rst_n && (!in_v_r || take);
  assign batch_valid = in_v_r;
  assign batch       = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (take) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      op_r <= in_ch.operation;
      ch_r <= in_ch.char_code;
    end
  end

  // next row with wrap back to the top
  assign row_inc  = {1'b0, row_r} + (tccw_pkg::ROW_W+1)'(1);
  assign row_wrap = (row_inc >= (tccw_pkg::ROW_W+1)'(tccw_pkg::SCREEN_ROWS)) ?
                    '0 : row_inc[tccw_pkg::ROW_W-1:0];
  assign col_inc  = {1'b0, col_r} + (tccw_pkg::COL_W+1)'(1);
  assign col_end  = col_inc >= (tccw_pkg::COL_W+1)'(tccw_pkg::SCREEN_COLUMNS);
  assign col_dec  = col_r - tccw_pkg::COL_W'(1);

  always_comb begin
    b       = '0;
    col_nxt = col_r;
    row_nxt = row_r;
    priority if (op_r == tccw_pkg::OP_CLEAR_SCREEN) begin
      b.slot[0] = tccw_pkg::mk_clear_screen();
      b.slot[1] = tccw_pkg::mk_cursor('0, '0);
      b.count   = 3'd2;
      col_nxt   = '0;
      row_nxt   = '0;
    end else if (ch_r == tccw_pkg::CHAR_NEWLINE) begin
      b.slot[0] = tccw_pkg::mk_clear_row(row_wrap, text_attribute);
      b.slot[1] = tccw_pkg::mk_cursor(row_wrap, '0);
      b.count   = 3'd2;
      col_nxt   = '0;
      row_nxt   = row_wrap;
    end else if (ch_r == tccw_pkg::CHAR_BACKSPACE) begin
      // column 0: nothing happens
      if (col_r != '0) begin
        b.slot[0] = tccw_pkg::mk_write(row_r, col_dec, tccw_pkg::CHAR_SPACE, text_attribute);
        b.slot[1] = tccw_pkg::mk_cursor(row_r, col_r);
        b.slot[2] = tccw_pkg::mk_cursor(row_r, col_dec);
        b.count   = 3'd3;
        col_nxt   = col_dec;
      end
    end else if (ch_r == tccw_pkg::CHAR_RETURN) begin
      b.slot[0] = tccw_pkg::mk_cursor(row_r, '0);
      b.count   = 3'd1;
      col_nxt   = '0;
    end else begin
      b.slot[0] = tccw_pkg::mk_write(row_r, col_r, ch_r, text_attribute);
      if (col_end) begin
        // end of row: new line, then the cursor is reported twice
        b.slot[1] = tccw_pkg::mk_clear_row(row_wrap, text_attribute);
        b.slot[2] = tccw_pkg::mk_cursor(row_wrap, '0);
        b.slot[3] = tccw_pkg::mk_cursor(row_wrap, '0);
        b.count   = 3'd4;
        col_nxt   = '0;
        row_nxt   = row_wrap;
      end else begin
        b.slot[1] = tccw_pkg::mk_cursor(row_r, col_inc[tccw_pkg::COL_W-1:0]);
        b.count   = 3'd2;
        col_nxt   = col_inc[tccw_pkg::COL_W-1:0];
      end
    end
  end

endmodule

/* src/tccw_seq.sv */
// Result register bank that hands out one batch's beats in order.
module tccw_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  tccw_pkg::batch_t   batch,
  input  logic               batch_valid,
  output logic               batch_ready,
  tccw_out_if.source         out_ch
);

  tccw_pkg::result_t [3:0] slot_r;
  logic [2:0] cnt_r;
  logic       pop;
  logic       load;

  assign pop         = out_ch.valid && out_ch.ready;
  assign batch_ready = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ch.ready);
  assign load        = batch_valid && batch_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= batch.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= batch.slot;
    end else if (pop) begin
      slot_r <= {slot_r[3], slot_r[3:1]};
    end
  end

  assign out_ch.valid           = cnt_r != 3'd0;
  assign out_ch.action          = slot_r[0].action;
  assign out_ch.row             = slot_r[0].row;
  assign out_ch.column          = slot_r[0].column;
  assign out_ch.cell_char       = slot_r[0].cell_char;
  assign out_ch.cell_attribute  = slot_r[0].cell_attribute;
  assign out_ch.cursor_position = slot_r[0].cursor_position;
  assign out_ch.last            = cnt_r == 3'd1;

endmodule

/* src/text_console_cursor_writer.sv */
// Top level of the text console cursor writer.
// Commands arrive on in_ch: operation 1 clears the screen and homes the cursor,
// operation 0 puts char_code (newline, carriage return and backspace are handled
// as cursor controls, every other byte is written to the cell under the cursor).
// Each command yields zero to four beats on out_ch: cell writes, row clears,
// screen clears and cursor position updates; last marks the final beat of one
// command. The APB port holds text_attribute at address 0; write it only while idle.
// A command is registered on accept, decoded into a bank of result registers once
// the bank is free, and its first beat is driven straight from that bank.
// Throughput: one beat per cycle on out_ch while out_ch.ready is high; a command
// yields 1 to 4 beats, and a backspace in column 0 yields none.
// The result bank is the limit: the next batch loads as the last beat leaves.
// While out_ch stalls, one further command is still taken into the input register.
// Reset clears the cursor to row 0, column 0, drops pending beats and sets the
// attribute to 7; in_ch is not ready while reset is held.
module text_console_cursor_writer (
  input  logic        clk,
  input  logic        rst_n,
  tccw_in_if.sink     in_ch,
  tccw_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]       text_attribute;
  tccw_pkg::batch_t batch;
  logic             batch_valid;
  logic             batch_ready;

  tccw_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .text_attribute (text_attribute)
  );

  tccw_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .text_attribute (text_attribute),
    .batch          (batch),
    .batch_valid    (batch_valid),
    .batch_ready    (batch_ready)
  );

  tccw_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .batch       (batch),
    .batch_valid (batch_valid),
    .batch_ready (batch_ready),
    .out_ch      (out_ch)
  );

endmodule

/* src/tccw_checker.sv */
// Port-level checks for the text console cursor writer, bound to the top level.
module tccw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_action,
  input logic [4:0]  out_row,
  input logic [6:0]  out_column,
  input logic [10:0] out_cursor_position,
  input logic        out_last
);

  // a stalled beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) && $stable(out_row)
      && $stable(out_column) && $stable(out_cursor_position) && $stable(out_last))
    else $error("stalled beat changed");

  // cursor beats carry the linear position of their row and column
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == tccw_pkg::ACT_CURSOR |->
      out_cursor_position == tccw_pkg::cursor_pos(out_row, out_column))
    else $error("cursor position does not match row and column");

  // only cursor beats carry a position
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != tccw_pkg::ACT_CURSOR |-> out_cursor_position == '0)
    else $error("position on a non-cursor beat");

  // a screen clear is never final and is followed at once by a home cursor beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_action == tccw_pkg::ACT_CLEAR_SCREEN && !out_last |=>
      out_valid && out_action == tccw_pkg::ACT_CURSOR && out_cursor_position == '0
      && out_last)
    else $error("screen clear not followed by cursor home");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == tccw_pkg::ACT_CLEAR_SCREEN |-> !out_last)
    else $error("screen clear marked last");

endmodule

bind text_console_cursor_writer tccw_checker u_tccw_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_action          (out_ch.action),
  .out_row             (out_ch.row),
  .out_column          (out_ch.column),
  .out_cursor_position (out_ch.cursor_position),
  .out_last            (out_ch.last)
);
